// ----- rtl/wso_pkg.sv -----
package wso_pkg;

	localparam int DIAM_W    = 12;
	localparam int LOCKOUT_W = 16;
	localparam int TIME_W    = 32;
	localparam int PULSE_W   = 8;
	localparam int CIRC_W    = 22;
	localparam int PROD_W    = 30;
	localparam int DIST_W    = 22;
	localparam int NUMER_W   = 31;
	localparam int SPEED_W   = 16;
	localparam int TOTAL_W   = 40;
	localparam int PTOTAL_W  = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	typedef logic [TIME_W-1:0]   time_t;
	typedef logic [DIST_W-1:0]   dist_t;
	typedef logic [SPEED_W-1:0]  speed_t;
	typedef logic [CIRC_W-1:0]   circ_t;
	typedef logic [PROD_W-1:0]   prod_t;
	typedef logic [PULSE_W-1:0]  pulse_t;

	localparam logic [CFG_IDX_W-1:0] REG_DIAMETER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT  = 2'd1;

	localparam logic [DIAM_W-1:0]    DIAM_RESET    = 12'd0;
	localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = 16'd30;

	// pi in Q8
	localparam logic [9:0]         PI_Q8       = 10'd804;
	localparam logic [8:0]         SPEED_SCALE = 9'd360;
	localparam logic [PROD_W-1:0]  ROUND_HALF  = 30'd128;
	localparam speed_t             SPEED_MAX   = 16'hFFFF;
	localparam pulse_t             PULSE_MAX   = 8'hFF;

endpackage

// ----- rtl/wso_in_if.sv -----
interface wso_in_if;
	logic                       valid;
	logic                       ready;
	logic                       kind;
	logic [wso_pkg::TIME_W-1:0] timestamp_ms;

	modport source(output valid, output kind, output timestamp_ms, input ready);
	modport sink(input valid, input kind, input timestamp_ms, output ready);
endinterface

// ----- rtl/wso_out_if.sv -----
interface wso_out_if;
	logic                         valid;
	logic                         ready;
	logic [wso_pkg::DIST_W-1:0]   interval_distance_mm;
	logic [wso_pkg::SPEED_W-1:0]  average_speed;
	logic [wso_pkg::TOTAL_W-1:0]  total_distance_mm;
	logic [wso_pkg::PTOTAL_W-1:0] total_pulses;
	logic                         speed_clipped;
	logic                         zero_interval;

	modport source(output valid, output interval_distance_mm, output average_speed,
		output total_distance_mm, output total_pulses, output speed_clipped,
		output zero_interval, input ready);
	modport sink(input valid, input interval_distance_mm, input average_speed,
		input total_distance_mm, input total_pulses, input speed_clipped,
		input zero_interval, output ready);
endinterface

// ----- rtl/wso_cfg_if.sv -----
interface wso_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [wso_pkg::CFG_IDX_W-1:0] index;
	logic [wso_pkg::CFG_DAT_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ----- rtl/wso_serial_mult.sv -----
// Shift-add multiplier, one multiplier bit per cycle, MSB first.
module wso_serial_mult (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  wso_pkg::circ_t        multiplicand,
	input  wso_pkg::pulse_t       multiplier,
	output logic                  done,
	output wso_pkg::prod_t        product
);

	localparam int CNT_W = $clog2(wso_pkg::PULSE_W);

	wso_pkg::circ_t    a_q;
	wso_pkg::pulse_t   b_q;
	wso_pkg::prod_t    acc_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	wso_pkg::prod_t    addend;

	assign addend  = b_q[wso_pkg::PULSE_W-1] ? wso_pkg::PROD_W'(a_q) : '0;
	assign done    = done_q;
	assign product = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			acc_q  <= '0;
			a_q    <= '0;
			b_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				a_q    <= multiplicand;
				b_q    <= multiplier;
				acc_q  <= '0;
				cnt_q  <= CNT_W'(wso_pkg::PULSE_W - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				acc_q <= {acc_q[wso_pkg::PROD_W-2:0], 1'b0} + addend;
				b_q   <= {b_q[wso_pkg::PULSE_W-2:0], 1'b0};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ----- rtl/wso_serial_div.sv -----
// Restoring divider, one quotient bit per cycle. The upper part of the
// dividend (rem_init) must already be below the divisor, so the quotient
// fits in SPEED_W bits.
module wso_serial_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  wso_pkg::time_t             rem_init,
	input  wso_pkg::speed_t            dividend_lo,
	input  wso_pkg::time_t             divisor,
	output logic                       done,
	output wso_pkg::speed_t            quotient
);

	localparam int CNT_W = $clog2(wso_pkg::SPEED_W);

	wso_pkg::time_t              rem_q;
	wso_pkg::time_t              div_q;
	wso_pkg::speed_t             shreg_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [wso_pkg::TIME_W:0]    trial;
	logic [wso_pkg::TIME_W:0]    diff;
	logic                        fits;

	assign trial    = {rem_q, shreg_q[wso_pkg::SPEED_W-1]};
	assign diff     = trial - {1'b0, div_q};
	assign fits     = trial >= {1'b0, div_q};
	assign done     = done_q;
	assign quotient = shreg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
			rem_q   <= '0;
			div_q   <= '0;
			shreg_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q   <= rem_init;
				div_q   <= divisor;
				shreg_q <= dividend_lo;
				cnt_q   <= CNT_W'(wso_pkg::SPEED_W - 1);
				busy_q  <= 1'b1;
			end else if (busy_q) begin
				// dividend bits leave at the top, quotient bits enter at the bottom
				rem_q   <= fits ? diff[wso_pkg::TIME_W-1:0] : trial[wso_pkg::TIME_W-1:0];
				shreg_q <= {shreg_q[wso_pkg::SPEED_W-2:0], fits};
				cnt_q   <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ----- rtl/wheel_speed_odometer.sv -----
// Wheel speed and odometer.
// Channels: items (sink) carries kind and timestamp_ms, kind 0 is a wheel
// sensor edge and kind 1 a sample request. results (source) carries one
// result per sample request. cfg (sink) writes wheel_diameter_mm (index 0)
// and lockout_ms (index 1); it is always ready, other indexes are ignored.
// An edge passes through S_EDGE, where the lockout is checked, and produces
// no result. A sample request runs an 8-step shift-add multiply for the
// distance, then two 16-step passes through the shared restoring divider
// (speed, then ring mean), the speed pass skipped when the elapsed time is
// zero or the speed clips. The next item is taken in the cycle after the
// result loads. One item is in work at a time.
// The result waits in an output register; while it waits, further items
// are taken, and a later sample holds in its final state until the
// register frees. A stalled receiver only stalls the next sample.
// Reset clears counts, totals, timestamps, the speed ring and the running
// ring sum, sets lockout_ms to 30 and the diameter to 0; items are taken
// from the first cycle after reset.
module wheel_speed_odometer #(
	parameter int AVERAGE_DEPTH = 3
) (
	input  logic      clk,
	input  logic      arst_n,
	wso_cfg_if.sink   cfg,
	wso_in_if.sink    items,
	wso_out_if.source results
);

	localparam int POS_W = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
	localparam int SUM_W = wso_pkg::SPEED_W + $clog2(AVERAGE_DEPTH);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(AVERAGE_DEPTH - 1);

	typedef enum logic [3:0] {
		S_IDLE, S_EDGE, S_LOAD, S_MULT, S_ROUND, S_SCALE, S_CHECK,
		S_DIV_SPD, S_RING, S_AVG_GO, S_DIV_AVG, S_OUT
	} state_t;

	state_t                           state_q;
	logic [wso_pkg::DIAM_W-1:0]       diameter_q;
	logic [wso_pkg::LOCKOUT_W-1:0]    lockout_q;
	wso_pkg::time_t                   ts_q;
	wso_pkg::pulse_t                  pulse_count_q;
	wso_pkg::time_t                   last_edge_q;
	wso_pkg::time_t                   last_sample_q;
	wso_pkg::time_t                   elapsed_q;
	wso_pkg::dist_t                   dist_q;
	logic [wso_pkg::NUMER_W-1:0]      numer_q;
	wso_pkg::speed_t                  speed_q;
	logic                             clipped_q;
	logic                             zero_q;
	wso_pkg::speed_t                  ring_q [AVERAGE_DEPTH];
	logic [POS_W-1:0]                 pos_q;
	logic [SUM_W-1:0]                 sum_q;
	logic [wso_pkg::TOTAL_W-1:0]      dist_total_q;
	logic [wso_pkg::PTOTAL_W-1:0]     pulse_total_q;
	logic                             out_valid_q;
	wso_pkg::dist_t                   out_dist_q;
	wso_pkg::speed_t                  out_avg_q;
	logic [wso_pkg::TOTAL_W-1:0]      out_total_q;
	logic [wso_pkg::PTOTAL_W-1:0]     out_pulses_q;
	logic                             out_clip_q;
	logic                             out_zero_q;

	logic                             in_xfer;
	logic                             out_xfer;
	logic                             out_free;
	wso_pkg::time_t                   gap;
	logic                             edge_ok;
	logic                             mult_start;
	logic                             mult_done;
	wso_pkg::circ_t                   circ;
	wso_pkg::prod_t                   product;
	wso_pkg::prod_t                   rounded;
	logic                             speed_sat;
	logic                             div_start;
	logic                             div_done;
	wso_pkg::time_t                   div_rem;
	wso_pkg::speed_t                  div_lo;
	wso_pkg::time_t                   div_den;
	wso_pkg::speed_t                  quotient;
	wso_pkg::time_t                   sum_ext;

	assign cfg.ready   = 1'b1;
	assign items.ready = (state_q == S_IDLE);
	assign in_xfer     = items.valid && items.ready;
	assign out_xfer    = out_valid_q && results.ready;
	assign out_free    = !out_valid_q || results.ready;

	assign gap     = ts_q - last_edge_q;
	assign edge_ok = (gap[wso_pkg::TIME_W-1:wso_pkg::LOCKOUT_W] != '0) ||
		(gap[wso_pkg::LOCKOUT_W-1:0] > lockout_q);

	assign circ       = wso_pkg::CIRC_W'(diameter_q) * wso_pkg::CIRC_W'(wso_pkg::PI_Q8);
	assign mult_start = (state_q == S_LOAD);
	assign rounded    = product + wso_pkg::ROUND_HALF;

	// quotient reaches 2^16 exactly when the top part is not below the divisor
	assign speed_sat = wso_pkg::TIME_W'(numer_q[wso_pkg::NUMER_W-1:wso_pkg::SPEED_W]) >= elapsed_q;
	assign sum_ext   = wso_pkg::TIME_W'(sum_q);

	always_comb begin
		div_start = 1'b0;
		div_rem   = wso_pkg::TIME_W'(numer_q[wso_pkg::NUMER_W-1:wso_pkg::SPEED_W]);
		div_lo    = numer_q[wso_pkg::SPEED_W-1:0];
		div_den   = elapsed_q;
		if (state_q == S_CHECK) begin
			div_start = (elapsed_q != '0) && !speed_sat;
		end else if (state_q == S_AVG_GO) begin
			div_start = 1'b1;
			div_rem   = sum_ext >> wso_pkg::SPEED_W;
			div_lo    = sum_ext[wso_pkg::SPEED_W-1:0];
			div_den   = wso_pkg::TIME_W'(AVERAGE_DEPTH);
		end
	end

	wso_serial_mult u_mult (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (mult_start),
		.multiplicand (circ),
		.multiplier   (pulse_count_q),
		.done         (mult_done),
		.product      (product)
	);

	wso_serial_div u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (div_start),
		.rem_init    (div_rem),
		.dividend_lo (div_lo),
		.divisor     (div_den),
		.done        (div_done),
		.quotient    (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diameter_q <= wso_pkg::DIAM_RESET;
			lockout_q  <= wso_pkg::LOCKOUT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				wso_pkg::REG_DIAMETER: diameter_q <= cfg.data[wso_pkg::DIAM_W-1:0];
				wso_pkg::REG_LOCKOUT:  lockout_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			ts_q          <= '0;
			pulse_count_q <= '0;
			last_edge_q   <= '0;
			last_sample_q <= '0;
			elapsed_q     <= '0;
			dist_q        <= '0;
			numer_q       <= '0;
			speed_q       <= '0;
			clipped_q     <= 1'b0;
			zero_q        <= 1'b0;
			for (int i = 0; i < AVERAGE_DEPTH; i++) ring_q[i] <= '0;
			pos_q         <= '0;
			sum_q         <= '0;
			dist_total_q  <= '0;
			pulse_total_q <= '0;
			out_valid_q   <= 1'b0;
			out_dist_q    <= '0;
			out_avg_q     <= '0;
			out_total_q   <= '0;
			out_pulses_q  <= '0;
			out_clip_q    <= 1'b0;
			out_zero_q    <= 1'b0;
		end else begin
			// in S_OUT a transfer frees the register and the next result loads it
			if (out_xfer && state_q != S_OUT) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						ts_q    <= items.timestamp_ms;
						state_q <= items.kind ? S_LOAD : S_EDGE;
					end
				end
				S_EDGE: begin
					if (edge_ok) begin
						if (pulse_count_q != wso_pkg::PULSE_MAX)
							pulse_count_q <= pulse_count_q + 1'b1;
						last_edge_q <= ts_q;
					end
					state_q <= S_IDLE;
				end
				S_LOAD: begin
					// multiplier latches the pulse count this cycle
					elapsed_q     <= ts_q - last_sample_q;
					last_sample_q <= ts_q;
					pulse_total_q <= pulse_total_q + wso_pkg::PTOTAL_W'(pulse_count_q);
					pulse_count_q <= '0;
					state_q       <= S_MULT;
				end
				S_MULT: begin
					if (mult_done) state_q <= S_ROUND;
				end
				S_ROUND: begin
					dist_q  <= rounded[wso_pkg::PROD_W-1:8];
					state_q <= S_SCALE;
				end
				S_SCALE: begin
					numer_q <= wso_pkg::NUMER_W'(dist_q) *
						wso_pkg::NUMER_W'(wso_pkg::SPEED_SCALE);
					dist_total_q <= dist_total_q + wso_pkg::TOTAL_W'(dist_q);
					state_q      <= S_CHECK;
				end
				S_CHECK: begin
					zero_q    <= 1'b0;
					clipped_q <= 1'b0;
					priority if (elapsed_q == '0) begin
						speed_q <= '0;
						zero_q  <= 1'b1;
						state_q <= S_RING;
					end else if (speed_sat) begin
						speed_q   <= wso_pkg::SPEED_MAX;
						clipped_q <= 1'b1;
						state_q   <= S_RING;
					end else begin
						state_q <= S_DIV_SPD;
					end
				end
				S_DIV_SPD: begin
					if (div_done) begin
						speed_q <= quotient;
						state_q <= S_RING;
					end
				end
				S_RING: begin
					// keep the ring sum current instead of re-adding every entry
					ring_q[pos_q] <= speed_q;
					sum_q   <= sum_q - SUM_W'(ring_q[pos_q]) + SUM_W'(speed_q);
					pos_q   <= (pos_q == POS_LAST) ? '0 : pos_q + 1'b1;
					state_q <= S_AVG_GO;
				end
				S_AVG_GO: begin
					state_q <= S_DIV_AVG;
				end
				S_DIV_AVG: begin
					if (div_done) state_q <= S_OUT;
				end
				S_OUT: begin
					// hold until the output register frees
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_dist_q   <= dist_q;
						out_avg_q    <= quotient;
						out_total_q  <= dist_total_q;
						out_pulses_q <= pulse_total_q;
						out_clip_q   <= clipped_q;
						out_zero_q   <= zero_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign results.valid                = out_valid_q;
	assign results.interval_distance_mm = out_dist_q;
	assign results.average_speed        = out_avg_q;
	assign results.total_distance_mm    = out_total_q;
	assign results.total_pulses         = out_pulses_q;
	assign results.speed_clipped        = out_clip_q;
	assign results.zero_interval        = out_zero_q;

endmodule

// ----- rtl/wso_checker.sv -----
module wso_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [wso_pkg::DIST_W-1:0]    out_dist,
	input logic [wso_pkg::PTOTAL_W-1:0]  out_pulses,
	input logic                          out_clip,
	input logic                          out_zero
);

	// a stalled result holds its interval distance and pulse total
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_dist) && $stable(out_pulses))
		else $error("result changed while stalled");

	// one item in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item taken while previous one in work");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_clip && out_zero))
		else $error("clipped and zero interval both set");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write refused");

endmodule

bind wheel_speed_odometer wso_checker u_wso_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cfg_valid  (cfg.valid),
	.cfg_ready  (cfg.ready),
	.in_valid   (items.valid),
	.in_ready   (items.ready),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.out_dist   (results.interval_distance_mm),
	.out_pulses (results.total_pulses),
	.out_clip   (results.speed_clipped),
	.out_zero   (results.zero_interval)
);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

	localparam int CLK_PERIOD   = 8;
	localparam int RESET_CYCLES = 9;
	localparam int SETTLE       = 64;
	localparam int HOLD_CYCLES  = 400;
	localparam int QUIET_LIMIT  = 4000;
	localparam int AVG_DEPTH    = 3;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 20;
	localparam int PLAN_ROWS    = 26;

	localparam logic KIND_EDGE   = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	localparam logic [wso_pkg::CFG_IDX_W-1:0] REG_DIAM     = wso_pkg::REG_DIAMETER;
	localparam logic [wso_pkg::CFG_IDX_W-1:0] REG_LOCK     = wso_pkg::REG_LOCKOUT;
	localparam logic [wso_pkg::CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
	localparam logic [wso_pkg::CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

	typedef struct packed {
		wso_pkg::dist_t                 span_mm;
		wso_pkg::speed_t                mean_speed;
		logic [wso_pkg::TOTAL_W-1:0]    odo_mm;
		logic [wso_pkg::PTOTAL_W-1:0]   odo_pulses;
		logic                           clipped;
		logic                           zero_dt;
	} odo_reading_t;

	typedef enum logic [1:0] {ROW_EDGE, ROW_SAMPLE, ROW_CFG} row_op_t;

	typedef struct packed {
		row_op_t                        op;
		wso_pkg::time_t                 ts;
		logic [15:0]                    rep;
		logic [wso_pkg::CFG_IDX_W-1:0]  idx;
		logic [wso_pkg::CFG_DAT_W-1:0]  dat;
		logic                           typed;
		odo_reading_t                   want;
	} stim_row_t;

	localparam odo_reading_t NO_READING = '0;

	// Edge rows with rep > 1 send that many edges, one ms apart.
	localparam stim_row_t PLAN [PLAN_ROWS] = '{
		'{ROW_SAMPLE, 32'h0000_0000, 16'd1, REG_DIAM, 16'd0, 1'b1,
			'{22'd0, 16'd0, 40'd0, 32'd0, 1'b0, 1'b1}},
		'{ROW_CFG, 32'h0, 16'd1, REG_DIAM, 16'd4095, 1'b0, NO_READING},
		'{ROW_EDGE, 32'd10, 16'd1, REG_DIAM, 16'd0, 1'b0, NO_READING},
		'{ROW_EDGE, 32'd31, 16'd1, REG_DIAM, 16'd0, 1'b0, NO_READING},
		'{ROW_EDGE, 32'd61, 16'd1, REG_DIAM, 16'd0, 1'b0, NO_READING},
		'{ROW_SAMPLE, 32'd1, 16'd1, REG_DIAM, 16'd0, 1'b1,
			'{22'd12861, 16'd21845, 40'd12861, 32'd1, 1'b1, 1'b0}},
		'{ROW_SAMPLE, 32'd1, 16'd1, REG_DIAM, 16'd0, 1'b1,
			'{22'd0, 16'd21845, 40'd12861, 32'd1, 1'b0, 1'b1}},
		'{ROW_CFG, 32'h0, 16'd1, REG_LOCK, 16'd0, 1'b0, NO_READING},
		'{ROW_CFG, 32'h0, 16'd1, REG_UNUSED_2, 16'hFFFF, 1'b0, NO_READING},
		'{ROW_CFG, 32'h0, 16'd1, REG_UNUSED_3, 16'h1234, 1'b0, NO_READING},
		'{ROW_EDGE, 32'hFFFF_FFFF, 16'd1, REG_DIAM, 16'd0, 1'b0, NO_READING},
		'{ROW_EDGE, 32'hFFFF_FFFF, 16'd1, REG_DIAM, 16'd0, 1'b0, NO_READING},
		'{ROW_EDGE, 32'h0000_0000, 16'd1, REG_DIAM, 16'd0, 1'b0, NO_READING},
		'{ROW_SAMPLE, 32'h0000_0100, 16'd1, REG_DIAM, 16'd0, 1'b0, NO_READING},
		'{ROW_EDGE, 32'h0000_1000, 16'd260, REG_DIAM, 16'd0, 1'b0, NO_READING},
		'{ROW_SAMPLE, 32'h0010_0000, 16'd1, REG_DIAM, 16'd0, 1'b0, NO_READING},
		'{ROW_CFG, 32'h0, 16'd1, REG_LOCK, 16'hFFFF, 1'b0, NO_READING},
		'{ROW_CFG, 32'h0, 16'd1, REG_DIAM, 16'd1, 1'b0, NO_READING},
		'{ROW_EDGE, 32'h0010_FFFF, 16'd1, REG_DIAM, 16'd0, 1'b0, NO_READING},
		'{ROW_EDGE, 32'h0011_FFFE, 16'd1, REG_DIAM, 16'd0, 1'b0, NO_READING},
		'{ROW_EDGE, 32'h0011_FFFF, 16'd1, REG_DIAM, 16'd0, 1'b0, NO_READING},
		'{ROW_SAMPLE, 32'hFFFF_FFF0, 16'd1, REG_DIAM, 16'd0, 1'b0, NO_READING},
		'{ROW_SAMPLE, 32'h0000_0010, 16'd1, REG_DIAM, 16'd0, 1'b0, NO_READING},
		'{ROW_CFG, 32'h0, 16'd1, REG_DIAM, 16'd0, 1'b0, NO_READING},
		'{ROW_EDGE, 32'h0020_0000, 16'd1, REG_DIAM, 16'd0, 1'b0, NO_READING},
		'{ROW_SAMPLE, 32'h0020_0005, 16'd1, REG_DIAM, 16'd0, 1'b0, NO_READING}
	};

	logic clk = 1'b0;
	logic arst_n;

	wso_cfg_if cfg_bus ();
	wso_in_if  item_bus ();
	wso_out_if result_bus ();

	wheel_speed_odometer uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_bus),
		.items   (item_bus),
		.results (result_bus)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// odometer shadow state
	logic [wso_pkg::DIAM_W-1:0]    wheel_mm       = wso_pkg::DIAM_RESET;
	logic [wso_pkg::LOCKOUT_W-1:0] lockout_cfg    = wso_pkg::LOCKOUT_RESET;
	wso_pkg::pulse_t               pulse_tally    = '0;
	wso_pkg::time_t                last_edge_ts   = '0;
	wso_pkg::time_t                last_sample_ts = '0;
	wso_pkg::speed_t               speed_hist [AVG_DEPTH] = '{default: '0};
	int unsigned                   hist_slot      = 0;
	logic [wso_pkg::TOTAL_W-1:0]   dist_sum       = '0;
	logic [wso_pkg::PTOTAL_W-1:0]  pulse_sum      = '0;

	odo_reading_t pending_readings [$];

	int unsigned mismatches = 0;
	int unsigned items_sent = 0;
	int unsigned readings_checked = 0;
	int unsigned clipped_seen = 0;
	int unsigned zero_dt_seen = 0;
	int unsigned reg_writes = 0;
	int unsigned idle_odds = 3;
	bit          calm = 1'b0;
	bit          hold_pending = 1'b0;

	task automatic odometer_predict(input logic kind, input wso_pkg::time_t ts,
		output bit produced, output odo_reading_t r);
		wso_pkg::time_t  gap;
		logic [63:0]     scaled;
		logic [63:0]     raw;
		logic [63:0]     ring_total;
		wso_pkg::pulse_t taken;
		wso_pkg::speed_t speed;
		produced = 1'b0;
		r = '0;
		if (kind == KIND_EDGE) begin
			gap = ts - last_edge_ts;
			if (gap > wso_pkg::time_t'(lockout_cfg)) begin
				if (pulse_tally != wso_pkg::PULSE_MAX)
					pulse_tally = pulse_tally + 1'b1;
				last_edge_ts = ts;
			end
			return;
		end
		taken = pulse_tally;
		pulse_tally = '0;
		gap = ts - last_sample_ts;
		// round half up after the Q8 pi product
		scaled = 64'(taken) * 64'(wheel_mm) * 64'(wso_pkg::PI_Q8) + 64'd128;
		r.span_mm = wso_pkg::dist_t'(scaled >> 8);
		if (gap == '0) begin
			speed = '0;
			r.zero_dt = 1'b1;
		end else begin
			raw = 64'(r.span_mm) * 64'(wso_pkg::SPEED_SCALE) / 64'(gap);
			if (raw > 64'(wso_pkg::SPEED_MAX)) begin
				speed = wso_pkg::SPEED_MAX;
				r.clipped = 1'b1;
			end else begin
				speed = wso_pkg::speed_t'(raw);
			end
		end
		speed_hist[hist_slot] = speed;
		hist_slot = (hist_slot == AVG_DEPTH - 1) ? 0 : hist_slot + 1;
		ring_total = '0;
		foreach (speed_hist[k])
			ring_total = ring_total + 64'(speed_hist[k]);
		r.mean_speed = wso_pkg::speed_t'(ring_total / AVG_DEPTH);
		dist_sum = dist_sum + wso_pkg::TOTAL_W'(r.span_mm);
		pulse_sum = pulse_sum + wso_pkg::PTOTAL_W'(taken);
		last_sample_ts = ts;
		r.odo_mm = dist_sum;
		r.odo_pulses = pulse_sum;
		produced = 1'b1;
	endtask

	task automatic report(input string what, input longint unsigned got,
		input longint unsigned want);
		mismatches++;
		$display("mismatch on %s at reading %0d: got %0d, expected %0d",
			what, readings_checked, got, want);
	endtask

	task automatic check_reading();
		odo_reading_t want;
		if (pending_readings.size() == 0) begin
			report("unexpected reading", 1, 0);
			return;
		end
		want = pending_readings.pop_front();
		readings_checked++;
		if (want.clipped)
			clipped_seen++;
		if (want.zero_dt)
			zero_dt_seen++;
		if (result_bus.interval_distance_mm !== want.span_mm)
			report("interval_distance_mm", result_bus.interval_distance_mm, want.span_mm);
		if (result_bus.average_speed !== want.mean_speed)
			report("average_speed", result_bus.average_speed, want.mean_speed);
		if (result_bus.total_distance_mm !== want.odo_mm)
			report("total_distance_mm", result_bus.total_distance_mm, want.odo_mm);
		if (result_bus.total_pulses !== want.odo_pulses)
			report("total_pulses", result_bus.total_pulses, want.odo_pulses);
		if (result_bus.speed_clipped !== want.clipped)
			report("speed_clipped", result_bus.speed_clipped, want.clipped);
		if (result_bus.zero_interval !== want.zero_dt)
			report("zero_interval", result_bus.zero_interval, want.zero_dt);
	endtask

	task automatic send_item(input logic kind, input wso_pkg::time_t ts, input logic typed,
		input odo_reading_t want);
		bit           produced;
		odo_reading_t r;
		item_bus.valid        <= 1'b1;
		item_bus.kind         <= kind;
		item_bus.timestamp_ms <= ts;
		do
			@(posedge clk);
		while (item_bus.ready !== 1'b1);
		items_sent++;
		odometer_predict(kind, ts, produced, r);
		if (produced)
			pending_readings.push_back(typed ? want : r);
	endtask

	task automatic item_gap();
		if (!calm && $urandom_range(0, idle_odds) == 0) begin
			item_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 7))
				@(posedge clk);
		end
	endtask

	// Hold the input side until every reading is back and the block is quiet.
	task automatic drain_idle();
		item_bus.valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE)
			@(posedge clk);
	endtask

	task automatic write_register(input logic [wso_pkg::CFG_IDX_W-1:0] idx,
		input logic [wso_pkg::CFG_DAT_W-1:0] dat);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= dat;
		do
			@(posedge clk);
		while (cfg_bus.ready !== 1'b1);
		// drop valid for one cycle so back-to-back writes stay separate
		cfg_bus.valid <= 1'b0;
		@(posedge clk);
		reg_writes++;
		if (idx == REG_DIAM)
			wheel_mm = dat[wso_pkg::DIAM_W-1:0];
		else if (idx == REG_LOCK)
			lockout_cfg = dat[wso_pkg::LOCKOUT_W-1:0];
	endtask

	// receiver: random stalls plus one long hold-off on request
	initial begin
		int unsigned hold_left;
		int unsigned stall_left;
		logic        nxt;
		hold_left = 0;
		stall_left = 0;
		result_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
				check_reading();
			if (hold_pending) begin
				hold_pending = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				nxt = 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				nxt = 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 6);
				nxt = 1'b0;
			end else begin
				nxt = 1'b1;
			end
			result_bus.ready <= nxt;
		end
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((item_bus.valid === 1'b1 && item_bus.ready === 1'b1) ||
				(result_bus.valid === 1'b1 && result_bus.ready === 1'b1) ||
				(cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
		$display("status: fail");
		$finish;
	end

	initial begin
		int                             sent;
		int                             n;
		wso_pkg::time_t                 now;
		wso_pkg::time_t                 ts;
		logic [wso_pkg::CFG_DAT_W-1:0]  diam;
		logic [wso_pkg::CFG_DAT_W-1:0]  lock;
		arst_n                <= 1'b0;
		cfg_bus.valid         <= 1'b0;
		cfg_bus.index         <= REG_DIAM;
		cfg_bus.data          <= '0;
		item_bus.valid        <= 1'b0;
		item_bus.kind         <= KIND_EDGE;
		item_bus.timestamp_ms <= '0;
		repeat (RESET_CYCLES)
			@(posedge clk);
		arst_n <= 1'b1;

		foreach (PLAN[i]) begin
			unique case (PLAN[i].op)
				ROW_CFG: begin
					drain_idle();
					write_register(PLAN[i].idx, PLAN[i].dat);
				end
				ROW_EDGE: begin
					for (int k = 0; k < PLAN[i].rep; k++) begin
						send_item(KIND_EDGE, PLAN[i].ts + wso_pkg::time_t'(k), 1'b0,
							NO_READING);
						item_gap();
					end
				end
				default: begin
					send_item(KIND_SAMPLE, PLAN[i].ts, PLAN[i].typed, PLAN[i].want);
					item_gap();
				end
			endcase
		end

		now = 32'h0030_0000;
		for (int phase = 0; phase < PHASES; phase++) begin
			unique case (phase)
				0: begin diam = 16'd4095; lock = 16'd0; end
				1: begin diam = 16'($urandom_range(1, 4095)); lock = 16'hFFFF; end
				2: begin diam = 16'($urandom_range(200, 1000)); lock = 16'd30; end
				3: begin diam = 16'd0; lock = 16'($urandom_range(0, 100)); end
				4: begin diam = 16'($urandom_range(0, 4095)); lock = 16'($urandom); end
				5: begin diam = 16'd4095; lock = 16'($urandom_range(0, 50)); end
				6: begin diam = 16'($urandom_range(0, 4095)); lock = 16'($urandom_range(0, 200)); end
				default: begin diam = 16'($urandom_range(400, 800)); lock = 16'd20; end
			endcase
			drain_idle();
			write_register(REG_DIAM, diam);
			write_register(REG_LOCK, lock);
			idle_odds = (phase % 2 != 0) ? 2 : 6;
			calm = (phase == PHASES - 1);
			// let the output back up while inputs keep coming
			if (phase == 2)
				hold_pending = 1'b1;
			// cross the 2^32 ms wrap
			if (phase == 5)
				now = 32'hFFFF_F000;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(0, 9) == 0) begin
					send_item($urandom_range(0, 1) != 0, wso_pkg::time_t'($urandom), 1'b0,
						NO_READING);
					item_gap();
					sent++;
				end else begin
					n = $urandom_range(0, 12);
					repeat (n) begin
						if ($urandom_range(0, 3) == 0)
							now = now + wso_pkg::time_t'($urandom_range(0, lockout_cfg));
						else
							now = now + wso_pkg::time_t'(lockout_cfg) +
								wso_pkg::time_t'($urandom_range(1, 150));
						send_item(KIND_EDGE, now, 1'b0, NO_READING);
						item_gap();
						sent++;
					end
					if ($urandom_range(0, 11) == 0) begin
						ts = last_sample_ts;
					end else begin
						now = now + wso_pkg::time_t'($urandom_range(0, 60));
						ts = now;
					end
					send_item(KIND_SAMPLE, ts, 1'b0, NO_READING);
					item_gap();
					sent++;
				end
			end
		end

		drain_idle();
		$display("run: %0d items over %0d directed rows and %0d random phases, %0d register writes",
			items_sent, PLAN_ROWS, PHASES, reg_writes);
		$display("run: %0d readings checked, %0d with clipped speed, %0d with zero interval",
			readings_checked, clipped_seen, zero_dt_seen);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
